// ===== sv/i2p_pkg.sv =====
// i2p_pkg: word types, character codes, class and priority functions and the
// control store of the infix to prefix converter
// no dependencies
package i2p_pkg;

  // one input word and one result word
  typedef struct packed {
    logic [7:0] symbol;
    logic       final_symbol;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_symbol;
    logic       has_symbol;
    logic       final_out;
    logic       overflowed;
  } out_word_t;

  // character codes
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;

  // character classes, in the order of the dispatch steps
  typedef enum logic [1:0] {
    CLS_ALNUM,
    CLS_OPEN,
    CLS_CLOSE,
    CLS_OTHER
  } cls_t;

  // sequencer steps; the four dispatch targets must stay consecutive
  typedef enum logic [4:0] {
    S_LOAD,
    S_SCAN,
    S_CLASS,
    S_D_ALNUM,
    S_D_OPEN,
    S_D_CLOSE,
    S_D_OTHER,
    S_CLOSE_TEST,
    S_CLOSE_END,
    S_CLOSE_POP,
    S_OP_TEST,
    S_OP_PUSH,
    S_OP_POP,
    S_DRAIN_RD,
    S_DRAIN_POP,
    S_OUT_RD,
    S_OUT_SHOW,
    S_OUT_LOOP,
    S_DONE,
    S_EMPTY,
    S_EMPTY_END
  } step_t;

  // jump conditions
  typedef enum logic [3:0] {
    C_NEXT,
    C_ALWAYS,
    C_LOAD_WAIT,
    C_K_ZERO,
    C_DISPATCH,
    C_CLOSE_GO,
    C_OP_GO,
    C_DEPTH_ZERO,
    C_OC_ZERO,
    C_OC_NONZERO,
    C_OUT_BUSY
  } cond_t;

  // source of a character written to the output store
  typedef enum logic [1:0] {
    EM_NONE,
    EM_CUR,
    EM_TOP,
    EM_TOP_NOPEN
  } emit_t;

  typedef struct packed {
    cond_t cond;
    step_t target;
    logic  accept;
    logic  in_rd;
    logic  latch_cur;
    logic  stk_rd;
    logic  push;
    logic  pop;
    emit_t emit;
    logic  out_rd;
    logic  out_load;
    logic  out_empty;
    logic  clr_ovf;
  } uword_t;

  // operator stack control and status
  typedef struct packed {
    logic push;
    logic pop;
    logic rd;
  } stk_ctrl_t;

  typedef struct packed {
    logic       empty;
    logic [7:0] top;
  } stk_stat_t;

  // parentheses trade places for the reversed scan
  function automatic logic [7:0] swap_paren(logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c == CH_LPAREN) r = CH_RPAREN;
    else if (c == CH_RPAREN) r = CH_LPAREN;
    return r;
  endfunction

  function automatic cls_t classify(logic [7:0] c);
    cls_t r;
    if ((c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
        (c >= 8'h61 && c <= 8'h7A)) r = CLS_ALNUM;
    else if (c == CH_LPAREN) r = CLS_OPEN;
    else if (c == CH_RPAREN) r = CLS_CLOSE;
    else r = CLS_OTHER;
    return r;
  endfunction

  // priority, shifted up by one so that the lowest level is 0
  function automatic logic [1:0] prio(logic [7:0] c);
    logic [1:0] r;
    if (c == CH_CARET) r = 2'd3;
    else if (c == CH_STAR || c == CH_SLASH) r = 2'd2;
    else if (c == CH_PLUS || c == CH_MINUS) r = 2'd1;
    else r = 2'd0;
    return r;
  endfunction

  // control store: one word per step
  function automatic uword_t ucode(step_t s);
    uword_t w;
    w        = '0;
    w.cond   = C_NEXT;
    w.target = S_LOAD;
    w.emit   = EM_NONE;
    case (s)
      S_LOAD: begin
        w.accept = 1'b1;
        w.cond   = C_LOAD_WAIT;
        w.target = S_LOAD;
      end
      S_SCAN: begin
        w.in_rd  = 1'b1;
        w.cond   = C_K_ZERO;
        w.target = S_DRAIN_RD;
      end
      S_CLASS: begin
        w.latch_cur = 1'b1;
        w.stk_rd    = 1'b1;
        w.cond      = C_DISPATCH;
        w.target    = S_D_ALNUM;
      end
      S_D_ALNUM: begin
        w.emit   = EM_CUR;
        w.cond   = C_ALWAYS;
        w.target = S_SCAN;
      end
      S_D_OPEN: begin
        w.push   = 1'b1;
        w.cond   = C_ALWAYS;
        w.target = S_SCAN;
      end
      S_D_CLOSE: begin
        w.cond   = C_ALWAYS;
        w.target = S_CLOSE_TEST;
      end
      S_D_OTHER: begin
        w.cond   = C_ALWAYS;
        w.target = S_OP_TEST;
      end
      S_CLOSE_TEST: begin
        w.cond   = C_CLOSE_GO;
        w.target = S_CLOSE_POP;
      end
      S_CLOSE_END: begin
        w.pop    = 1'b1;
        w.cond   = C_ALWAYS;
        w.target = S_SCAN;
      end
      S_CLOSE_POP: begin
        w.emit   = EM_TOP;
        w.pop    = 1'b1;
        w.stk_rd = 1'b1;
        w.cond   = C_ALWAYS;
        w.target = S_CLOSE_TEST;
      end
      S_OP_TEST: begin
        w.cond   = C_OP_GO;
        w.target = S_OP_POP;
      end
      S_OP_PUSH: begin
        w.push   = 1'b1;
        w.cond   = C_ALWAYS;
        w.target = S_SCAN;
      end
      S_OP_POP: begin
        w.emit   = EM_TOP;
        w.pop    = 1'b1;
        w.stk_rd = 1'b1;
        w.cond   = C_ALWAYS;
        w.target = S_OP_TEST;
      end
      S_DRAIN_RD: begin
        w.stk_rd = 1'b1;
        w.cond   = C_DEPTH_ZERO;
        w.target = S_OUT_RD;
      end
      S_DRAIN_POP: begin
        w.emit   = EM_TOP_NOPEN;
        w.pop    = 1'b1;
        w.cond   = C_ALWAYS;
        w.target = S_DRAIN_RD;
      end
      S_OUT_RD: begin
        w.out_rd = 1'b1;
        w.cond   = C_OC_ZERO;
        w.target = S_EMPTY;
      end
      S_OUT_SHOW: begin
        w.out_load = 1'b1;
        w.cond     = C_OUT_BUSY;
        w.target   = S_OUT_SHOW;
      end
      S_OUT_LOOP: begin
        w.cond   = C_OC_NONZERO;
        w.target = S_OUT_RD;
      end
      S_DONE: begin
        w.clr_ovf = 1'b1;
        w.cond    = C_ALWAYS;
        w.target  = S_LOAD;
      end
      S_EMPTY: begin
        w.out_load  = 1'b1;
        w.out_empty = 1'b1;
        w.cond      = C_OUT_BUSY;
        w.target    = S_EMPTY;
      end
      S_EMPTY_END: begin
        w.cond   = C_ALWAYS;
        w.target = S_DONE;
      end
      default: begin
        w.cond   = C_ALWAYS;
        w.target = S_LOAD;
      end
    endcase
    return w;
  endfunction

endpackage

// ===== sv/infix_to_prefix_converter.sv =====
// infix_to_prefix_converter: accepts one input word per cycle while loading; after the
// final word it scans the stored string from the last word back, emits operands at once
// and operators through the stack, then empties the stack and sends the stored result
// words last to first, or an empty marker, each held while out_ready is low; loading
// resumes after the last one is registered; synchronous active-high rst clears step,
// counts, stack depth, overflow flag and output valid; stores are not cleared
module infix_to_prefix_converter import i2p_pkg::*; #(
  parameter int MAX_LEN = 64
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  localparam int AW = $clog2(MAX_LEN);
  localparam int CW = $clog2(MAX_LEN + 1);

  // sequencer
  step_t  step;
  step_t  step_next;
  uword_t uw;
  logic   jump;

  // input store, scan position is the fill count counting down
  logic [7:0]    in_mem [MAX_LEN];
  logic [CW-1:0] in_count;
  logic [CW-1:0] in_last;
  logic [7:0]    in_rdata;
  logic          in_acc;
  logic          in_wr;
  logic          in_rd_en;

  // current character of the scan, parentheses already swapped
  logic [7:0] cur;
  logic [7:0] cur_next;
  cls_t       cur_cls;

  // output store
  logic [7:0]    out_mem [MAX_LEN];
  logic [CW-1:0] oc;
  logic [CW-1:0] oc_last;
  logic [7:0]    out_rdata;
  logic          emit_en;
  logic [7:0]    emit_char;
  logic          out_rd_en;

  logic ovf;

  // operator stack
  stk_ctrl_t stk_ctrl;
  stk_stat_t stk_stat;
  logic      op_go;
  logic      close_go;

  // output register
  logic      out_free;
  logic      out_ld;
  out_word_t out_word_next;

  assign uw       = ucode(step);
  assign in_ready = uw.accept;
  assign in_acc   = in_valid && in_ready;
  assign in_wr    = in_acc && (in_count < CW'(MAX_LEN));
  assign in_last  = in_count - CW'(1);
  assign in_rd_en = uw.in_rd && (in_count != '0);
  assign oc_last  = oc - CW'(1);
  assign out_rd_en = uw.out_rd && (oc != '0);

  assign cur_next = swap_paren(in_rdata);
  assign cur_cls  = classify(cur_next);

  // pop on a higher-priority top, or on equal priority when the incoming op is ^
  assign close_go = !stk_stat.empty && (stk_stat.top != CH_LPAREN);
  assign op_go    = close_go &&
                    ((prio(cur) < prio(stk_stat.top)) ||
                     ((prio(cur) == prio(stk_stat.top)) && (cur == CH_CARET)));

  assign out_free = !out_valid || out_ready;
  assign out_ld   = uw.out_load && out_free;

  // emit source
  always_comb begin
    emit_en   = 1'b0;
    emit_char = cur;
    case (uw.emit)
      EM_NONE: emit_en = 1'b0;
      EM_CUR: begin
        emit_en   = 1'b1;
        emit_char = cur;
      end
      EM_TOP: begin
        emit_en   = 1'b1;
        emit_char = stk_stat.top;
      end
      EM_TOP_NOPEN: begin
        emit_en   = (stk_stat.top != CH_LPAREN);
        emit_char = stk_stat.top;
      end
      default: emit_en = 1'b0;
    endcase
  end

  assign stk_ctrl.push = uw.push;
  assign stk_ctrl.pop  = uw.pop;
  assign stk_ctrl.rd   = uw.stk_rd;

  i2p_stack #(
    .MAX_LEN(MAX_LEN)
  ) u_stack (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (stk_ctrl),
    .push_data(cur),
    .stat     (stk_stat)
  );

  // jump condition select
  always_comb begin
    case (uw.cond)
      C_NEXT:       jump = 1'b0;
      C_ALWAYS:     jump = 1'b1;
      C_LOAD_WAIT:  jump = !(in_valid && in_data.final_symbol);
      C_K_ZERO:     jump = (in_count == '0);
      C_DISPATCH:   jump = 1'b1;
      C_CLOSE_GO:   jump = close_go;
      C_OP_GO:      jump = op_go;
      C_DEPTH_ZERO: jump = stk_stat.empty;
      C_OC_ZERO:    jump = (oc == '0);
      C_OC_NONZERO: jump = (oc != '0);
      C_OUT_BUSY:   jump = !out_free;
      default:      jump = 1'b1;
    endcase
  end

  // next step: fall through, jump, or dispatch on the character class
  always_comb begin
    if (!jump) step_next = step_t'(5'(step) + 5'd1);
    else if (uw.cond == C_DISPATCH) step_next = step_t'(5'(uw.target) + 5'(cur_cls));
    else step_next = uw.target;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= S_LOAD;
    end else begin
      step <= step_next;
    end
  end

  // counts and overflow flag
  always_ff @(posedge clk) begin
    if (rst) begin
      in_count <= '0;
      oc       <= '0;
      ovf      <= 1'b0;
    end else begin
      if (in_wr) in_count <= in_count + CW'(1);
      else if (in_rd_en) in_count <= in_last;
      if (in_acc && !in_wr) ovf <= 1'b1;
      else if (uw.clr_ovf) ovf <= 1'b0;
      if (emit_en && oc < CW'(MAX_LEN)) oc <= oc + CW'(1);
      else if (out_rd_en) oc <= oc_last;
    end
  end

  // store access
  always_ff @(posedge clk) begin
    if (in_wr) in_mem[in_count[AW-1:0]] <= in_data.symbol;
    if (in_rd_en) in_rdata <= in_mem[in_last[AW-1:0]];
    if (emit_en && oc < CW'(MAX_LEN)) out_mem[oc[AW-1:0]] <= emit_char;
    if (out_rd_en) out_rdata <= out_mem[oc_last[AW-1:0]];
    if (uw.latch_cur) cur <= cur_next;
  end

  // result word; the store is read last to first, so count zero marks the end
  always_comb begin
    out_word_next.out_symbol = uw.out_empty ? 8'd0 : out_rdata;
    out_word_next.has_symbol = !uw.out_empty;
    out_word_next.final_out  = uw.out_empty || (oc == '0);
    out_word_next.overflowed = ovf;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ld) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ld) out_data <= out_word_next;
  end

endmodule

// ===== sv/i2p_stack.sv =====
// i2p_stack: operator stack memory with depth counter and registered top read
// depends on i2p_pkg
module i2p_stack import i2p_pkg::*; #(
  parameter int MAX_LEN = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  stk_ctrl_t  ctrl,
  input  logic [7:0] push_data,
  output stk_stat_t  stat
);

  localparam int AW = $clog2(MAX_LEN);
  localparam int CW = $clog2(MAX_LEN + 1);

  logic [7:0]    mem [MAX_LEN];
  logic [CW-1:0] depth;
  logic [CW-1:0] depth_next;
  logic [CW-1:0] rd_ptr;
  logic [7:0]    top;
  logic          do_push;
  logic          do_pop;

  assign do_push = ctrl.push && (depth < CW'(MAX_LEN));
  assign do_pop  = ctrl.pop && (depth != '0);

  always_comb begin
    depth_next = depth;
    if (do_push) depth_next = depth + CW'(1);
    else if (do_pop) depth_next = depth - CW'(1);
  end

  // the read always targets the top after this cycle's update
  assign rd_ptr = depth_next - CW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      depth <= '0;
    end else begin
      depth <= depth_next;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[depth[AW-1:0]] <= push_data;
    if (ctrl.rd && depth_next != '0) top <= mem[rd_ptr[AW-1:0]];
  end

  assign stat.empty = (depth == '0);
  assign stat.top   = top;

endmodule

// ===== sv/i2p_checker.sv =====
// i2p_checker: port-level checks for the infix to prefix converter, with bind
// depends on i2p_pkg and infix_to_prefix_converter
module i2p_checker import i2p_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_ready,
  input in_word_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_word_t out_data
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // the empty marker is always the last word of its expression
  a_empty_final: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.has_symbol |-> out_data.final_out)
    else $error("empty marker without final flag");

  // overflow flag is the same on back-to-back words of one expression
  a_ovf_steady: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_data.final_out ##1 out_valid
    |-> out_data.overflowed == $past(out_data.overflowed))
    else $error("overflow flag changed inside an expression");

  // a non-final input word never produces a result at once
  a_no_early_out: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !in_data.final_symbol && !out_valid |=> !out_valid)
    else $error("result before the final input word");

endmodule

bind infix_to_prefix_converter i2p_checker u_i2p_checker (
  .clk      (clk),
  .rst      (rst),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .in_data  (in_data),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);
